// ===== design/xcxbc_pkg.sv =====
// Shared types and constants for the xorshift chained-XOR byte cipher.
package xcxbc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BYTE_W = 8;

	// Commands from the cipher controller to the remainder unit.
	typedef struct packed {
		logic start;
		logic ack;
	} div_cmd_t;

	// Status from the remainder unit back to the controller.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== design/xcxbc_divider.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module xcxbc_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  xcxbc_pkg::div_cmd_t            cmd,
	input  logic [xcxbc_pkg::WORD_W-1:0]   dividend,
	input  logic [xcxbc_pkg::WORD_W-1:0]   divisor,
	output xcxbc_pkg::div_stat_t           stat,
	output logic [xcxbc_pkg::WORD_W-1:0]   remainder
);
	import xcxbc_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] dvs_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W:0]   trial;
	logic              fits;
	logic [WORD_W-1:0] rem_next;

	// Shift in the next dividend bit and subtract when the divisor fits.
	// A zero divisor always fits and subtracts nothing.
	assign trial    = {rem_q, dvd_q[WORD_W-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign rem_next = fits ? WORD_W'(trial - {1'b0, dvs_q}) : trial[WORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (cmd.ack) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

// ===== design/xorshift_chained_xor_byte_cipher.sv =====
// Top level of the xorshift keystream chained-XOR byte cipher.
// An item passes through the load into the remainder unit, its 32 bit-serial steps
// and the handoff to the output register, which waits while that register is full.
// A new item is accepted only once the previous one has been handed off.
// A finished item waits in the output register while the next item is accepted.
// Reset (arst_n low, asynchronous) restores the register defaults, seeds the generator
// and clears the chain byte; no clearing pass is needed.
module xorshift_chained_xor_byte_cipher (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input item channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [xcxbc_pkg::BYTE_W-1:0]   data_in,
	input  logic                           restart,
	// Result item channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [xcxbc_pkg::BYTE_W-1:0]   data_out,
	// Configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [xcxbc_pkg::WORD_W-1:0]   cfg_data
);
	import xcxbc_pkg::*;

	// Register indexes
	localparam logic [1:0] REG_SEED    = 2'd0;
	localparam logic [1:0] REG_START   = 2'd1;
	localparam logic [1:0] REG_MODULUS = 2'd2;
	localparam logic [1:0] REG_DECRYPT = 2'd3;

	// Reset values
	localparam logic [WORD_W-1:0] SEED_RST    = 32'd2463534242;
	localparam logic [BYTE_W-1:0] START_RST   = 8'd0;
	localparam logic [WORD_W-1:0] MODULUS_RST = 32'hFFFF_FFFF;

	// One xorshift32 step with shifts 13, 17 and 4.
	function automatic logic [WORD_W-1:0] gen_next(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		a = v ^ (v << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 4);
	endfunction

	logic [WORD_W-1:0] seed_q;
	logic [BYTE_W-1:0] start_q;
	logic [WORD_W-1:0] modulus_q;
	logic              decrypt_q;

	logic [WORD_W-1:0] prng_q;
	logic [BYTE_W-1:0] chain_q;
	logic [BYTE_W-1:0] din_q;
	logic              busy_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] data_out_q;

	logic              in_acc;
	logic              out_free;
	logic              take;
	logic [WORD_W-1:0] word;
	logic [BYTE_W-1:0] chain_src;
	logic [BYTE_W-1:0] result;
	logic [WORD_W-1:0] remainder;
	div_cmd_t          div_cmd;
	div_stat_t         div_stat;

	// Configuration is always taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= SEED_RST;
			start_q   <= START_RST;
			modulus_q <= MODULUS_RST;
			decrypt_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SEED:    seed_q    <= cfg_data;
				REG_START:   start_q   <= cfg_data[BYTE_W-1:0];
				REG_MODULUS: modulus_q <= cfg_data;
				REG_DECRYPT: decrypt_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// Accept a byte only while no other byte is in flight; the output register
	// is separate, so a waiting result does not hold off the next byte.
	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;

	// Step the generator at accept time; restart reloads the seed and the chain first.
	assign word      = gen_next(restart ? seed_q : prng_q);
	assign chain_src = restart ? start_q : chain_q;

	// Hand the finished remainder to the output register once it is free.
	assign out_free = !out_valid_q || !out_stall;
	assign take     = div_stat.done && busy_q && out_free;
	assign result   = chain_q ^ din_q ^ remainder[BYTE_W-1:0];

	assign div_cmd.start = in_acc;
	assign div_cmd.ack   = take;

	xcxbc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.dividend  (word),
		.divisor   (modulus_q),
		.stat      (div_stat),
		.remainder (remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prng_q      <= SEED_RST;
			chain_q     <= START_RST;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				prng_q  <= word;
				chain_q <= chain_src;
				busy_q  <= 1'b1;
			end else if (take) begin
				// Advance the chain: cipher byte in both modes.
				chain_q <= decrypt_q ? din_q : result;
				busy_q  <= 1'b0;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			din_q <= data_in;
		end
		if (take) begin
			data_out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (!div_stat.busy && !div_stat.done))
		else $error("byte accepted while remainder unit still holds work");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> div_stat.busy)
		else $error("remainder unit did not start after accept");

	a_busy_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (div_stat.busy || div_stat.done))
		else $error("byte in flight without remainder unit activity");

	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (out_valid && !busy_q))
		else $error("finished byte not loaded into output register");
`endif

endmodule

// ===== bench/xorshift_chained_xor_byte_cipher_tb.sv =====
// Self-checking testbench for the xorshift chained-XOR byte cipher.
module xorshift_chained_xor_byte_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xcxbc_pkg::*;

	// Configuration register map.
	typedef enum logic [1:0] {
		REG_SEED    = 2'd0,
		REG_START   = 2'd1,
		REG_MODULUS = 2'd2,
		REG_DECRYPT = 2'd3
	} cfg_reg_e;

	localparam int unsigned RANDOM_ITEMS = 1600;
	// Slowest run: ~1650 items plus output stalls and config traffic.
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned SETTLE_CYCLES = 40;

	// Tracks the keystream and chain byte, and holds the bytes the block owes us.
	class cipher_tracker;
		logic [WORD_W-1:0] seed, modulus, gen;
		logic [BYTE_W-1:0] start, chain;
		logic              decrypt;
		logic [BYTE_W-1:0] expected_bytes[$];
		int unsigned       bytes_in, bytes_out, restarts, reg_writes, errors;

		function new();
			seed     = 32'd2463534242;
			start    = '0;
			modulus  = 32'hFFFF_FFFF;
			decrypt  = 1'b0;
			gen      = seed;
			chain    = start;
			bytes_in = 0;
			bytes_out = 0;
			restarts = 0;
			reg_writes = 0;
			errors   = 0;
		endfunction

		// Register writes only update the shadow copies; state picks them up on restart.
		function void write_reg(cfg_reg_e idx, logic [WORD_W-1:0] v);
			reg_writes++;
			case (idx)
				REG_SEED:    seed    = v;
				REG_START:   start   = v[BYTE_W-1:0];
				REG_MODULUS: modulus = v;
				REG_DECRYPT: decrypt = v[0];
				default: ;
			endcase
		endfunction

		// Advance xorshift32 (13, 17, 4) and reduce; a zero divisor leaves the word as is.
		function logic [BYTE_W-1:0] next_key();
			logic [WORD_W-1:0] w, rem;
			w = gen;
			w ^= w << 13;
			w ^= w >> 17;
			w ^= w << 4;
			gen = w;
			rem = (modulus != '0) ? (w % modulus) : w;
			return rem[BYTE_W-1:0];
		endfunction

		function void note_byte(logic [BYTE_W-1:0] d, logic r);
			logic [BYTE_W-1:0] key, res;
			if (r) begin
				gen   = seed;
				chain = start;
				restarts++;
			end
			key   = next_key();
			res   = chain ^ d ^ key;
			chain = decrypt ? d : res;
			expected_bytes.push_back(res);
			bytes_in++;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_byte(logic [BYTE_W-1:0] d);
			logic [BYTE_W-1:0] want;
			bytes_out++;
			if (expected_bytes.size() == 0) begin
				report($sformatf("data_out %02h arrived with nothing pending", d));
				return;
			end
			want = expected_bytes.pop_front();
			if (d !== want)
				report($sformatf("data_out %02h, expected %02h (result %0d)",
					d, want, bytes_out));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [BYTE_W-1:0]  data_in;
	logic               restart;
	logic               out_valid;
	logic               out_stall;
	logic [BYTE_W-1:0]  data_out;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [WORD_W-1:0]  cfg_data;

	cipher_tracker      tracker;
	logic               calm;          // high during the stretch with no idling
	int unsigned        cycle_count;
	int unsigned        key_settings;

	xorshift_chained_xor_byte_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_in   (data_in),
		.restart   (restart),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Sample every handshake at the edge, using the values the block itself saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_reg_e'(cfg_index), cfg_data);
			if (in_valid && !in_stall)
				tracker.note_byte(data_in, restart);
			if (out_valid && !out_stall)
				tracker.check_byte(data_out);
		end
	end

	// Stall the result side about one cycle in ten, except during the calm stretch.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 10);
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, tracker.expected_bytes.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one item and hold it until accepted; idle the input now and then first.
	// Drop any config valid left high by the last register write.
	task automatic send_item(input logic [BYTE_W-1:0] d, input logic r);
		cfg_valid <= 1'b0;
		while (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_in  <= d;
		restart  <= r;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold valid high across back-to-back writes; the next item or drain lowers it.
	task automatic write_cfg(input cfg_reg_e idx, input logic [WORD_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Stop offering input and wait for every owed byte to come back.
	// The first edge lets the monitor note an item accepted on this same edge.
	task automatic drain_results();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		int unsigned base;
		bit          noisy;
		logic [WORD_W-1:0] modv;
		cfg_reg_e    idx;

		tracker      = new();
		calm         = 1'b0;
		cycle_count  = 0;
		key_settings = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		data_in   <= '0;
		restart   <= 1'b0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SEED;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: run straight off the reset seed, then restart mid-stream.
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hA5, 1'b1);
		send_item(8'h5A, 1'b0);

		// A new start value must not touch the chain until the next restart.
		drain_results();
		write_cfg(REG_START, 32'h0000_00C3);
		send_item(8'h11, 1'b0);
		send_item(8'h22, 1'b1);

		// Zero seed locks the generator at zero; zero modulus skips the reduction.
		drain_results();
		write_cfg(REG_SEED, 32'h0000_0000);
		write_cfg(REG_MODULUS, 32'h0000_0000);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		drain_results();
		write_cfg(REG_SEED, 32'hFFFF_FFFF);
		send_item(8'h01, 1'b1);
		send_item(8'hFE, 1'b0);

		// Modulus of one forces a zero key; chain starts from an all-ones byte.
		drain_results();
		write_cfg(REG_MODULUS, 32'h0000_0001);
		write_cfg(REG_START, 32'hFFFF_FFFF);
		send_item(8'h7F, 1'b1);
		send_item(8'hFF, 1'b0);

		// Decrypt at the widest modulus: chain follows the received byte.
		drain_results();
		write_cfg(REG_MODULUS, 32'hFFFF_FFFF);
		write_cfg(REG_DECRYPT, 32'h0000_0001);
		write_cfg(REG_SEED, 32'h8000_0001);
		write_cfg(REG_START, 32'h0000_0000);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b1);

		// Image-sized modulus (4x3 pixels, three channels, plus one), encrypting.
		drain_results();
		write_cfg(REG_MODULUS, 32'd37);
		write_cfg(REG_DECRYPT, 32'h0000_0000);
		send_item(8'h3C, 1'b1);
		send_item(8'hC3, 1'b0);
		send_item(8'h96, 1'b0);

		// Random part: each burst picks a fresh key setting and sends one message
		// that opens with a restart; a few messages skip it or restart midway.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_results();
			calm = (sent >= 500 && sent < 800);
			case ($urandom_range(5))
				0:       modv = 32'h0000_0000;
				1:       modv = 32'h0000_0001;
				2:       modv = 32'hFFFF_FFFF;
				3:       modv = 3 * $urandom_range(1, 64) * $urandom_range(1, 64) + 1;
				default: modv = $urandom;
			endcase
			// Write registers starting at a random index; skip some so old values carry.
			base = $urandom_range(3);
			for (int k = 0; k < 4; k++) begin
				idx = cfg_reg_e'((base + k) % 4);
				if ($urandom_range(99) < 80) begin
					case (idx)
						REG_SEED:    write_cfg(idx, ($urandom_range(9) == 0) ? '0 : $urandom);
						REG_START:   write_cfg(idx, $urandom);
						REG_MODULUS: write_cfg(idx, modv);
						default:     write_cfg(idx, $urandom_range(1));
					endcase
				end
			end
			key_settings++;
			len   = $urandom_range(4, 48);
			noisy = ($urandom_range(99) < 15);
			for (int i = 0; i < len; i++) begin
				calm = (sent >= 500 && sent < 800);
				send_item(BYTE_W'($urandom_range(255)),
					(i == 0) ? !noisy : ($urandom_range(99) < 3));
				sent++;
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d bytes (%0d restarts) over %0d random key settings",
			tracker.bytes_in, tracker.restarts, key_settings);
		$display("checked %0d output bytes after %0d register writes, %0d mismatches",
			tracker.bytes_out, tracker.reg_writes, tracker.errors);
		if (tracker.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
